/* hw/rtl/bgs_pkg.sv */
// ----------------------------------------------------------------------------
// Bilinear grid sampler package
// Shared constants, register codes and the types passed between the front
// end, the item queue and the back end of the sampler.
// ----------------------------------------------------------------------------
package bgs_pkg;

  // Default store bounds.
  localparam int DEF_MAX_WIDTH    = 64;
  localparam int DEF_MAX_HEIGHT   = 64;
  localparam int DEF_MAX_CHANNELS = 4;

  // At most this many results come from one sample.
  localparam int RESULT_CAP = 4;

  // Configuration register data width.
  localparam int CFG_DATA_W = 7;

  // Signed integer pixel coordinate, Q15 fraction and the mapped Q.15 value.
  localparam int COORD_W = 10;
  localparam int FRAC_W  = 15;
  localparam int Q_W     = 25;

  // Q30 bilinear weight, at most 2^30.
  localparam int WEIGHT_W = 31;

  // Depth of the queue between front and back end.
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    REG_WIDTH_IN         = 2'd0,
    REG_HEIGHT_IN        = 2'd1,
    REG_CHANNEL_COUNT    = 2'd2,
    REG_CORNER_ALIGNMENT = 2'd3
  } reg_index_t;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

  // Effective (clamped) configuration.
  typedef struct packed {
    logic [6:0] width;
    logic [6:0] height;
    logic [2:0] nch;
    logic       corner;
  } cfg_t;

  // One classified item as it travels through the queue.
  typedef struct packed {
    opcode_t                    op;
    logic [1:0]                 chan;
    logic [5:0]                 row;
    logic [5:0]                 col;
    logic signed [15:0]         pixel;
    logic signed [COORD_W-1:0]  x0;
    logic signed [COORD_W-1:0]  y0;
    logic [WEIGHT_W-1:0]        wa;
    logic [WEIGHT_W-1:0]        wb;
    logic [WEIGHT_W-1:0]        wc;
    logic [WEIGHT_W-1:0]        wd;
  } entry_t;

endpackage

/* hw/rtl/bilinear_grid_sampler.sv */
// ----------------------------------------------------------------------------
// Bilinear grid sampler
// Holds one multi-channel image and samples it at normalized grid points
// with bilinear interpolation and zero padding.
// ----------------------------------------------------------------------------
// Path: a sample passes the mapping register, the queue, the bank read, the
// weighting register and the output register; its channel results then
// follow one per cycle. Flow: the front end takes no item while one is in its
// mapping stage or the queue is full; the back end reads one channel per cycle
// for a sample (four bank reads each) and pops a load at the head of the queue.
// Reset restores register defaults; image contents are undefined until loaded.
module bilinear_grid_sampler #(
  parameter int MAX_WIDTH    = bgs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = bgs_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_CHANNELS = bgs_pkg::DEF_MAX_CHANNELS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           opcode,
  input  logic [1:0]                     chan,
  input  logic [5:0]                     row,
  input  logic [5:0]                     col,
  input  logic signed [15:0]             pixel_value,
  input  logic signed [15:0]             grid_x,
  input  logic signed [15:0]             grid_y,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [bgs_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           result_valid,
  output logic signed [15:0]             sample_value,
  output logic [1:0]                     out_channel,
  output logic                           last_of_run
);
  import bgs_pkg::*;

  localparam int CH_CAP = (MAX_CHANNELS < RESULT_CAP) ? MAX_CHANNELS : RESULT_CAP;

  logic [6:0] width_in;
  logic [6:0] height_in;
  logic [2:0] channel_count;
  logic       corner_alignment;
  cfg_t       cfg;
  logic       queue_full;
  logic       push;
  entry_t     push_entry;
  logic       pop;
  logic       head_valid;
  entry_t     head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_in         <= 7'd64;
      height_in        <= 7'd64;
      channel_count    <= 3'd4;
      corner_alignment <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_WIDTH_IN:         width_in         <= cfg_data[6:0];
        REG_HEIGHT_IN:        height_in        <= cfg_data[6:0];
        REG_CHANNEL_COUNT:    channel_count    <= cfg_data[2:0];
        REG_CORNER_ALIGNMENT: corner_alignment <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp registers to the supported ranges.
  always_comb begin
    if (width_in == '0) cfg.width = 7'd1;
    else if (int'(width_in) > MAX_WIDTH) cfg.width = 7'(MAX_WIDTH);
    else cfg.width = width_in;
    if (height_in == '0) cfg.height = 7'd1;
    else if (int'(height_in) > MAX_HEIGHT) cfg.height = 7'(MAX_HEIGHT);
    else cfg.height = height_in;
    if (channel_count == '0) cfg.nch = 3'd1;
    else if (int'(channel_count) > CH_CAP) cfg.nch = 3'(CH_CAP);
    else cfg.nch = channel_count;
    cfg.corner = corner_alignment;
  end

  bgs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .chan        (chan),
    .row         (row),
    .col         (col),
    .pixel_value (pixel_value),
    .grid_x      (grid_x),
    .grid_y      (grid_y),
    .cfg         (cfg),
    .queue_full  (queue_full),
    .push        (push),
    .push_entry  (push_entry)
  );

  bgs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  bgs_back #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .sample_value (sample_value),
    .out_channel  (out_channel),
    .last_of_run  (last_of_run)
  );

endmodule

/* hw/rtl/bgs_front.sv */
// ----------------------------------------------------------------------------
// Sampler front end
// Accepts items, maps grid coordinates to pixel space and forms the four
// bilinear weights, then pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module bgs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                opcode,
  input  logic [1:0]          chan,
  input  logic [5:0]          row,
  input  logic [5:0]          col,
  input  logic signed [15:0]  pixel_value,
  input  logic signed [15:0]  grid_x,
  input  logic signed [15:0]  grid_y,
  input  bgs_pkg::cfg_t       cfg,
  input  logic                queue_full,
  output logic                push,
  output bgs_pkg::entry_t     push_entry
);
  import bgs_pkg::*;

  logic                  accept;
  logic                  s1_valid;
  opcode_t               s1_op;
  logic [1:0]            s1_chan;
  logic [5:0]            s1_row;
  logic [5:0]            s1_col;
  logic signed [15:0]    s1_pixel;
  logic signed [Q_W-1:0] s1_qx;
  logic signed [Q_W-1:0] s1_qy;
  logic signed [16:0]    gx;
  logic signed [16:0]    gy;
  logic [6:0]            sx;
  logic [6:0]            sy;
  logic signed [Q_W-1:0] qx_next;
  logic signed [Q_W-1:0] qy_next;
  logic [15:0]           fx;
  logic [15:0]           fy;
  logic [15:0]           ex;
  logic [15:0]           ey;

  // One item at a time in the mapping stage; the queue must have room.
  assign busy   = s1_valid || queue_full;
  assign accept = start && !busy;

  // Coordinate mapping: (g + 1) * scale, less a half pixel in edge mode.
  always_comb begin
    gx = $signed({grid_x[15], grid_x}) + 17'sd16384;
    gy = $signed({grid_y[15], grid_y}) + 17'sd16384;
    sx = cfg.corner ? 7'(cfg.width - 7'd1) : cfg.width;
    sy = cfg.corner ? 7'(cfg.height - 7'd1) : cfg.height;
    qx_next = Q_W'(gx) * Q_W'($signed({1'b0, sx})) - Q_W'(cfg.corner ? 0 : 16384);
    qy_next = Q_W'(gy) * Q_W'($signed({1'b0, sy})) - Q_W'(cfg.corner ? 0 : 16384);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_op    <= opcode_t'(opcode);
      s1_chan  <= chan;
      s1_row   <= row;
      s1_col   <= col;
      s1_pixel <= pixel_value;
      s1_qx    <= qx_next;
      s1_qy    <= qy_next;
    end
  end

  // Split into floor and fraction, then build the Q30 weights.
  always_comb begin
    fx = {1'b0, s1_qx[FRAC_W-1:0]};
    fy = {1'b0, s1_qy[FRAC_W-1:0]};
    ex = 16'd32768 - fx;
    ey = 16'd32768 - fy;
    push_entry.op    = s1_op;
    push_entry.chan  = s1_chan;
    push_entry.row   = s1_row;
    push_entry.col   = s1_col;
    push_entry.pixel = s1_pixel;
    push_entry.x0    = s1_qx[Q_W-1:FRAC_W];
    push_entry.y0    = s1_qy[Q_W-1:FRAC_W];
    push_entry.wa    = WEIGHT_W'(32'(ex) * 32'(ey));
    push_entry.wb    = WEIGHT_W'(32'(ex) * 32'(fy));
    push_entry.wc    = WEIGHT_W'(32'(fx) * 32'(ey));
    push_entry.wd    = WEIGHT_W'(32'(fx) * 32'(fy));
  end

  assign push = s1_valid;

endmodule

/* hw/rtl/bgs_queue.sv */
// ----------------------------------------------------------------------------
// Sampler item queue
// A short first-in first-out queue of classified items between the front
// end and the back end.
// ----------------------------------------------------------------------------
module bgs_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bgs_pkg::entry_t  push_entry,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output bgs_pkg::entry_t  head
);
  import bgs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  entry_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_pop;

  assign full       = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= PTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      end
      count <= (PTR_W+1)'(count + (push ? 1 : 0) - (do_pop ? 1 : 0));
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("Queue written while full.");

endmodule

/* hw/rtl/bgs_back.sv */
// ----------------------------------------------------------------------------
// Sampler back end
// Holds the image in four parity banks, executes loads and, for samples,
// reads the four neighbours of one channel per cycle, weights, sums,
// rounds and saturates them.
// ----------------------------------------------------------------------------
module bgs_back #(
  parameter int MAX_WIDTH    = bgs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = bgs_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_CHANNELS = bgs_pkg::DEF_MAX_CHANNELS
) (
  input  logic               clk,
  input  logic               rst,
  input  bgs_pkg::cfg_t      cfg,
  input  logic               head_valid,
  input  bgs_pkg::entry_t    head,
  output logic               pop,
  output logic               result_valid,
  output logic signed [15:0] sample_value,
  output logic [1:0]         out_channel,
  output logic               last_of_run
);
  import bgs_pkg::*;

  localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
  localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = MAX_CHANNELS * HALF_H * HALF_W;
  localparam int BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int PROD_W     = WEIGHT_W + 17;
  localparam int SUM_W      = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << 29;

  logic [1:0]  ch;
  logic [1:0]  last_ch;
  logic        is_last;
  logic        issue;
  logic        load_now;
  logic        load_ok;
  logic [1:0]  load_bank;
  logic [BA_W-1:0] load_addr;

  logic [BA_W-1:0]     rd_addr [4];
  logic                nb_ok   [4];
  logic [WEIGHT_W-1:0] nb_w    [4];
  logic signed [15:0]  rdata   [4];

  logic                a_valid;
  logic [1:0]          a_ch;
  logic                a_last;
  logic                a_ok [4];
  logic [WEIGHT_W-1:0] a_w  [4];

  logic                     b_valid;
  logic [1:0]               b_ch;
  logic                     b_last;
  logic signed [PROD_W-1:0] b_prod [4];

  logic signed [SUM_W-1:0]    acc;
  logic signed [SUM_W-31:0]   rounded;
  logic signed [15:0]         sat;

  // Channel sequencing of the item at the head of the queue.
  assign last_ch  = 2'(cfg.nch - 3'd1);
  assign is_last  = (ch == last_ch);
  assign load_now = head_valid && (head.op == OP_LOAD);
  assign issue    = head_valid && (head.op == OP_SAMPLE);
  assign pop      = load_now || (issue && is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      ch <= '0;
    end else if (issue) begin
      ch <= is_last ? 2'd0 : 2'(ch + 2'd1);
    end
  end

  // Load placement: bank by row and column parity.
  always_comb begin
    load_ok   = (int'(head.chan) < MAX_CHANNELS) && (int'(head.row) < MAX_HEIGHT)
             && (int'(head.col) < MAX_WIDTH);
    load_bank = {head.row[0], head.col[0]};
    load_addr = BA_W'(int'(head.chan) * HALF_H * HALF_W
             + int'(head.row[5:1]) * HALF_W + int'(head.col[5:1]));
  end

  // Neighbour selection: each bank holds exactly one of the four neighbours.
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic                      xs;
      logic                      ys;
      logic signed [COORD_W-1:0] nx;
      logic signed [COORD_W-1:0] ny;
      xs = (head.x0[0] != b[0]);
      ys = (head.y0[0] != b[1]);
      nx = xs ? COORD_W'(head.x0 + COORD_W'(1)) : head.x0;
      ny = ys ? COORD_W'(head.y0 + COORD_W'(1)) : head.y0;
      nb_ok[b] = !nx[COORD_W-1] && !ny[COORD_W-1]
              && (nx < $signed({{(COORD_W-7){1'b0}}, cfg.width}))
              && (ny < $signed({{(COORD_W-7){1'b0}}, cfg.height}));
      rd_addr[b] = BA_W'(int'(ch) * HALF_H * HALF_W
                + int'(ny[COORD_W-1:1]) * HALF_W + int'(nx[COORD_W-1:1]));
      case ({xs, ys})
        2'b00:   nb_w[b] = head.wa;
        2'b01:   nb_w[b] = head.wb;
        2'b10:   nb_w[b] = head.wc;
        default: nb_w[b] = head.wd;
      endcase
    end
  end

  // Parity banks of the image store.
  for (genvar gb = 0; gb < 4; gb++) begin : g_bank
    logic signed [15:0] bank_mem [BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (load_now && load_ok && (load_bank == 2'(gb))) begin
        bank_mem[load_addr] <= head.pixel;
      end
      if (issue) begin
        rdata[gb] <= bank_mem[rd_addr[gb]];
      end
    end
  end

  // Read stage bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= issue;
    end
    if (issue) begin
      a_ch   <= ch;
      a_last <= is_last;
      for (int b = 0; b < 4; b++) begin
        a_ok[b] <= nb_ok[b];
        a_w[b]  <= nb_w[b];
      end
    end
  end

  // Weighting stage: one product per neighbour, zero outside the image.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    if (a_valid) begin
      b_ch   <= a_ch;
      b_last <= a_last;
      for (int b = 0; b < 4; b++) begin
        b_prod[b] <= a_ok[b]
                   ? PROD_W'($signed({1'b0, a_w[b]})) * PROD_W'(rdata[b])
                   : '0;
      end
    end
  end

  // Sum, round half up and saturate.
  always_comb begin
    acc = SUM_W'(b_prod[0]) + SUM_W'(b_prod[1]) + SUM_W'(b_prod[2])
        + SUM_W'(b_prod[3]) + ROUND_HALF;
    rounded = acc[SUM_W-1:30];
    if (rounded > (SUM_W-30)'(32767)) begin
      sat = 16'sh7FFF;
    end else if (rounded < -(SUM_W-30)'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = rounded[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= b_valid;
    end
    if (b_valid) begin
      sample_value <= sat;
      out_channel  <= b_ch;
      last_of_run  <= b_last;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    result_valid && last_of_run |-> out_channel == last_ch)
    else $error("Last result not on the final channel.");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_of_run |=> result_valid && out_channel == 2'($past(out_channel) + 2'd1))
    else $error("Channel results of one sample not contiguous.");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && out_channel == 2'd0 |-> !$past(result_valid) || $past(last_of_run))
    else $error("Channel zero result in the middle of a sample.");

endmodule

/* sim/bilinear_grid_sampler_tb.sv */
// ----------------------------------------------------------------------------
// Bilinear grid sampler testbench
// Fills the top-left corner of the image store, then runs several register
// settings. Small images get directed samples and a stretch of random load
// and sample transactions; large images are only sampled near the loaded
// corner or far outside. A scoreboard predicts and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bilinear_grid_sampler_tb;
  import bgs_pkg::*;

  typedef struct {
    logic signed [15:0] value;
    logic [1:0]         channel;
    logic               last;
  } sample_result_t;

  // Predicts the sampler and checks its channel results in order.
  class sampler_scoreboard;
    logic signed [15:0] image [0:DEF_MAX_CHANNELS*DEF_MAX_HEIGHT*DEF_MAX_WIDTH-1];
    int unsigned width, height, nch;
    bit corner;
    sample_result_t expected_results[$];
    int errors;
    int results_seen;

    function new();
      width = 64; height = 64; nch = 4; corner = 0;
      errors = 0; results_seen = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [6:0] data);
      case (idx)
        REG_WIDTH_IN: width = data;
        REG_HEIGHT_IN: height = data;
        REG_CHANNEL_COUNT: nch = data[2:0];
        REG_CORNER_ALIGNMENT: corner = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    // Grid value to pixel space: floor part and Q15 fraction.
    function void map_grid(logic signed [15:0] g, longint size,
                           output longint ipart, output longint frac);
      longint q;
      if (corner) q = (longint'(g) + 16384) * (size - 1);
      else q = (longint'(g) + 16384) * size - 16384;
      ipart = q >>> 15;
      frac = q & 32767;
    endfunction

    function longint pixel_at(int c, longint x, longint y, longint w, longint h);
      if (x < 0 || x >= w || y < 0 || y >= h) return 0;
      return longint'(image[(c * DEF_MAX_HEIGHT + y) * DEF_MAX_WIDTH + x]);
    endfunction

    // Notes one accepted transaction and queues the results it causes.
    function void note_input(opcode_t op, logic [1:0] ch, logic [5:0] r,
                             logic [5:0] k, logic signed [15:0] pv,
                             logic signed [15:0] gx, logic signed [15:0] gy);
      longint w, h, x0, y0, fx, fy, wa, wb, wc, wd, acc, v;
      int unsigned n;
      sample_result_t res;
      if (op == OP_LOAD) begin
        image[(int'(ch) * DEF_MAX_HEIGHT + r) * DEF_MAX_WIDTH + k] = pv;
        return;
      end
      w = clamp(width, DEF_MAX_WIDTH);
      h = clamp(height, DEF_MAX_HEIGHT);
      n = clamp(nch, RESULT_CAP);
      map_grid(gx, w, x0, fx);
      map_grid(gy, h, y0, fy);
      wa = (32768 - fx) * (32768 - fy);
      wb = (32768 - fx) * fy;
      wc = fx * (32768 - fy);
      wd = fx * fy;
      for (int c = 0; c < n; c++) begin
        acc = wa * pixel_at(c, x0, y0, w, h) + wb * pixel_at(c, x0, y0 + 1, w, h)
            + wc * pixel_at(c, x0 + 1, y0, w, h) + wd * pixel_at(c, x0 + 1, y0 + 1, w, h);
        v = (acc + (longint'(1) << 29)) >>> 30;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        res.value = v[15:0];
        res.channel = c[1:0];
        res.last = (c + 1 == n);
        expected_results.push_back(res);
      end
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task check_result(logic signed [15:0] value, logic [1:0] channel, logic last);
      sample_result_t exp_r;
      results_seen++;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result value %0d channel %0d", value, channel));
        return;
      end
      exp_r = expected_results.pop_front();
      if (value !== exp_r.value)
        report($sformatf("sample_value %0d, expected %0d", value, exp_r.value));
      if (channel !== exp_r.channel)
        report($sformatf("out_channel %0d, expected %0d", channel, exp_r.channel));
      if (last !== exp_r.last)
        report($sformatf("last_of_run %0b, expected %0b", last, exp_r.last));
    endtask

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 12;
  // Rows and columns of the loaded corner; small images stay inside it.
  localparam int FILL_SIZE = 8;
  localparam int FILL_ITEMS = DEF_MAX_CHANNELS * FILL_SIZE * FILL_SIZE;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic opcode = 0;
  logic [1:0] chan = 0;
  logic [5:0] row = 0;
  logic [5:0] col = 0;
  logic signed [15:0] pixel_value = 0;
  logic signed [15:0] grid_x = 0;
  logic signed [15:0] grid_y = 0;
  logic cfg_write = 0;
  logic [1:0] cfg_index = 0;
  logic [CFG_DATA_W-1:0] cfg_data = 0;
  logic result_valid;
  logic signed [15:0] sample_value;
  logic [1:0] out_channel;
  logic last_of_run;

  sampler_scoreboard sb = new();
  int idle_cycles = 0;
  int items_sent = 0;
  int samples_sent = 0;
  bit allow_gaps = 1;

  bilinear_grid_sampler u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .chan(chan), .row(row), .col(col), .pixel_value(pixel_value),
    .grid_x(grid_x), .grid_y(grid_y), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .result_valid(result_valid),
    .sample_value(sample_value), .out_channel(out_channel),
    .last_of_run(last_of_run)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Result monitor and watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) sb.check_result(sample_value, out_channel, last_of_run);
      if (result_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding", sb.pending());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Presents one transaction and holds it until accepted.
  task send_item(opcode_t op, logic [1:0] ch, logic [5:0] r, logic [5:0] k,
                 logic signed [15:0] pv, logic signed [15:0] gx,
                 logic signed [15:0] gy);
    int gap;
    gap = 0;
    if (allow_gaps)
      gap = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    opcode <= op; chan <= ch; row <= r; col <= k;
    pixel_value <= pv; grid_x <= gx; grid_y <= gy;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_input(op, ch, r, k, pv, gx, gy);
    items_sent++;
    if (op == OP_SAMPLE) samples_sent++;
  endtask

  task stop_items();
    start <= 0;
    @(posedge clk);
  endtask

  // Waits until the block is idle, then writes all four registers.
  task set_config(logic [6:0] w, logic [6:0] h, logic [6:0] n, logic [6:0] cor);
    logic [6:0] vals [4];
    vals = '{w, h, n, cor};
    stop_items();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1;
      cfg_index <= reg_index_t'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(reg_index_t'(i), vals[i]);
    end
    cfg_write <= 0;
    @(posedge clk);
  endtask

  function logic signed [15:0] rand_grid();
    case ($urandom_range(9))
      0: return 16'($urandom_range(0, 65535));
      1: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
      default: return 16'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // Grid values for a large image: next to the top-left corner or far outside.
  function logic signed [15:0] corner_grid();
    case ($urandom_range(3))
      0: return 16'(-32768 + int'($urandom_range(0, 4000)));
      1: return 16'(32767 - int'($urandom_range(0, 4000)));
      default: return 16'(-16384 + int'($urandom_range(0, 256)));
    endcase
  endfunction

  task send_sample(logic signed [15:0] gx, logic signed [15:0] gy);
    send_item(OP_SAMPLE, 2'($urandom), 6'($urandom), 6'($urandom), 16'($urandom),
              gx, gy);
  endtask

  task send_load(logic [1:0] ch, logic [5:0] r, logic [5:0] k, logic signed [15:0] pv);
    send_item(OP_LOAD, ch, r, k, pv, 16'($urandom), 16'($urandom));
  endtask

  // A load at a random place inside the filled corner.
  task send_random_load();
    send_load(2'($urandom), 6'($urandom_range(FILL_SIZE - 1)),
              6'($urandom_range(FILL_SIZE - 1)), 16'($urandom));
  endtask

  // Directed corners, center, far outside points and extreme pixels.
  task directed_part();
    send_load(0, 0, 0, 16'sh7fff);
    send_load(1, 0, 0, 16'sh8000);
    send_load(2, 0, 1, 16'sh8000);
    send_load(3, 1, 0, 16'sh7fff);
    send_load(0, 63, 63, 16'sh8000);
    send_sample(-16384, -16384);
    send_sample(16384, 16384);
    send_sample(-16384, 16384);
    send_sample(16384, -16384);
    send_sample(0, 0);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 0);
    send_sample(1, -1);
  endtask

  task random_part(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 3)
        send_random_load();
      else
        send_sample(rand_grid(), rand_grid());
    end
  endtask

  // Large images: every neighbour is in the filled corner or outside the image.
  task large_part(int count);
    send_sample(-16384, -16384);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(-16384, 16'sh7fff);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 3)
        send_random_load();
      else
        send_sample(corner_grid(), corner_grid());
    end
  endtask

  initial begin
    logic [6:0] cfg_w [6];
    logic [6:0] cfg_h [6];
    logic [6:0] cfg_n [6];
    logic [6:0] cfg_c [6];
    cfg_w = '{64, 1, 8, 0, 127, 5};
    cfg_h = '{64, 1, 8, 0, 127, 3};
    cfg_n = '{4, 1, 4, 0, 7, 2};
    cfg_c = '{0, 1, 1, 0, 1, 0};

    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // The corner is written first, so no sample reads an empty pixel.
    allow_gaps = 0;
    for (int c = 0; c < DEF_MAX_CHANNELS; c++)
      for (int r = 0; r < FILL_SIZE; r++)
        for (int k = 0; k < FILL_SIZE; k++)
          send_load(2'(c), 6'(r), 6'(k), 16'($urandom));

    for (int p = 0; p < 6; p++) begin
      allow_gaps = 1;
      if (p > 0) set_config(cfg_w[p], cfg_h[p], cfg_n[p], cfg_c[p]);
      if (int'(cfg_w[p]) > FILL_SIZE) begin
        large_part(24);
      end else begin
        directed_part();
        allow_gaps = (p != 2);
        random_part(24);
      end
    end
    stop_items();

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d transactions after the fill, %0d of them samples, %0d results.",
             items_sent - FILL_ITEMS, samples_sent, sb.results_seen);
    $display("Six register settings, including extreme and out-of-range values.");
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/bgs_pkg.sv
hw/rtl/bgs_front.sv
hw/rtl/bgs_queue.sv
hw/rtl/bgs_back.sv
hw/rtl/bilinear_grid_sampler.sv
sim/bilinear_grid_sampler_tb.sv
